// ----- rtl/core/palette_nearest_color_search_defines.svh -----
`ifndef PALETTE_NEAREST_COLOR_SEARCH_DEFINES_SVH
`define PALETTE_NEAREST_COLOR_SEARCH_DEFINES_SVH

// Plain check, sampled on clk, off during reset.
`define PNCS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication, sampled on clk, off during reset.
`define PNCS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/pncs_pkg.sv -----
package pncs_pkg;

	localparam int COMPONENT_BITS_DEF = 6;
	localparam int IN_COMP_W          = 6;
	localparam int FUNC_W             = 2;
	localparam int IDX_W              = 8;
	localparam int PAL_DEPTH          = 256;
	localparam int PACKED_W           = 15;
	localparam int PACK_FIELD_W       = 5;

	localparam logic [FUNC_W-1:0] FN_WRITE        = 2'd0;
	localparam logic [FUNC_W-1:0] FN_QUERY_RGB    = 2'd1;
	localparam logic [FUNC_W-1:0] FN_QUERY_PACKED = 2'd2;

	localparam logic [IDX_W-1:0] FIRST_CAND = 8'd255;
	localparam logic [IDX_W-1:0] SCAN_FIRST = 8'd1;
	localparam logic [IDX_W-1:0] SCAN_LAST  = 8'd253;
	localparam logic [IDX_W-1:0] NEVER_A   = 8'd0;
	localparam logic [IDX_W-1:0] NEVER_B   = 8'd254;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_OUT  = 3'b100
	} state_t;

endpackage

// ----- rtl/core/palette_nearest_color_search.sv -----
// Channel | Dir | Handshake           | Payload
// in      | in  | in_valid / in_ready | func, entry_index, red, green, blue, packed_rgb15
// out     | out | out_valid/out_ready | color_index
//
// A write stores one entry. A query reads one entry per cycle (255, then 1..253)
// through a read/square/compare pipe; the result is loaded once entry 253 is compared
// or on an exact match, and waits while the output register is still full.
// in_ready is high only while idle; a finished query holds the scanner (in_ready
// low) while the output register still holds an unaccepted result.
// arst_n clears control state only; the palette holds garbage until written.
`include "palette_nearest_color_search_defines.svh"

module palette_nearest_color_search #(
	parameter int COMPONENT_BITS = pncs_pkg::COMPONENT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [pncs_pkg::FUNC_W-1:0]         func,
	input  logic [pncs_pkg::IDX_W-1:0]          entry_index,
	input  logic [pncs_pkg::IN_COMP_W-1:0]      red,
	input  logic [pncs_pkg::IN_COMP_W-1:0]      green,
	input  logic [pncs_pkg::IN_COMP_W-1:0]      blue,
	input  logic [pncs_pkg::PACKED_W-1:0]       packed_rgb15,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pncs_pkg::IDX_W-1:0]          color_index
);
	import pncs_pkg::*;

	localparam int CW     = COMPONENT_BITS;
	localparam int PAL_W  = 3 * CW;
	localparam int SQ_W   = 2 * CW;
	localparam int DIST_W = SQ_W + 2;
	localparam int EXT_W  = IN_COMP_W + CW;

	state_t state_q;

	logic in_acc, wr_en, start, is_packed;
	logic [IN_COMP_W-1:0] src_r, src_g, src_b;
	logic [EXT_W-1:0] ext_r, ext_g, ext_b;
	logic [CW-1:0] in_r, in_g, in_b;

	logic [CW-1:0] qr_q, qg_q, qb_q;
	logic [PAL_W-1:0] pal_mem [PAL_DEPTH];

	logic             issue_on_q;
	logic [IDX_W-1:0] issue_idx_q, issue_next;
	logic             v_s1, last_s1, v_s2, last_s2;
	logic [IDX_W-1:0] idx_s1, idx_s2;
	logic [PAL_W-1:0] rdata_s1;
	logic [SQ_W-1:0]  sq_r_s2, sq_g_s2, sq_b_s2;
	logic [CW-1:0]    e_r, e_g, e_b, d_r, d_g, d_b;

	logic [DIST_W-1:0] cand_dist, best_dist_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic              take, hit, done;
	logic              out_free, out_load;
	logic              out_valid_q;
	logic [IDX_W-1:0]  color_index_q;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign color_index = color_index_q;

	assign in_acc    = in_valid && in_ready;
	assign wr_en     = in_acc && (func == FN_WRITE);
	assign start     = in_acc && (func == FN_QUERY_RGB || func == FN_QUERY_PACKED);
	assign is_packed = (func == FN_QUERY_PACKED);

	// packed fields are doubled, then everything is masked to the palette width
	assign src_r = is_packed ? {packed_rgb15[3*PACK_FIELD_W-1:2*PACK_FIELD_W], 1'b0} : red;
	assign src_g = is_packed ? {packed_rgb15[2*PACK_FIELD_W-1:PACK_FIELD_W], 1'b0} : green;
	assign src_b = is_packed ? {packed_rgb15[PACK_FIELD_W-1:0], 1'b0} : blue;
	assign ext_r = {{CW{1'b0}}, src_r};
	assign ext_g = {{CW{1'b0}}, src_g};
	assign ext_b = {{CW{1'b0}}, src_b};
	assign in_r  = ext_r[CW-1:0];
	assign in_g  = ext_g[CW-1:0];
	assign in_b  = ext_b[CW-1:0];

	// scan order: 255, then 1 up to 253
	assign issue_next = (issue_idx_q == FIRST_CAND) ? SCAN_FIRST : issue_idx_q + IDX_W'(1);

	// palette memory, one write and one read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pal_mem[entry_index] <= {in_r, in_g, in_b};
		end
		rdata_s1 <= pal_mem[issue_idx_q];
	end

	assign e_r = rdata_s1[3*CW-1:2*CW];
	assign e_g = rdata_s1[2*CW-1:CW];
	assign e_b = rdata_s1[CW-1:0];
	assign d_r = (qr_q > e_r) ? qr_q - e_r : e_r - qr_q;
	assign d_g = (qg_q > e_g) ? qg_q - e_g : e_g - qg_q;
	assign d_b = (qb_q > e_b) ? qb_q - e_b : e_b - qb_q;

	assign cand_dist = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);
	assign take = v_s2 && ((idx_s2 == FIRST_CAND) || (cand_dist < best_dist_q));
	assign hit  = take && (cand_dist == '0);
	assign done = v_s2 && (hit || last_s2);

	// output register is free when empty or drained this cycle
	assign out_free = !out_valid_q || out_ready;
	assign out_load = out_free && ((state_q == S_SCAN && done) || (state_q == S_OUT));

	always_ff @(posedge clk) begin
		if (start) begin
			qr_q <= in_r;
			qg_q <= in_g;
			qb_q <= in_b;
		end
		idx_s1  <= issue_idx_q;
		idx_s2  <= idx_s1;
		sq_r_s2 <= SQ_W'(d_r) * SQ_W'(d_r);
		sq_g_s2 <= SQ_W'(d_g) * SQ_W'(d_g);
		sq_b_s2 <= SQ_W'(d_b) * SQ_W'(d_b);
		if (take) begin
			best_dist_q <= cand_dist;
			best_idx_q  <= idx_s2;
		end
		// take is low while waiting, so best_idx_q is used then
		if (out_load) begin
			color_index_q <= take ? idx_s2 : best_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issue_on_q  <= 1'b0;
			issue_idx_q <= '0;
			v_s1        <= 1'b0;
			last_s1     <= 1'b0;
			v_s2        <= 1'b0;
			last_s2     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// anything still in the pipe after a finish is dropped
			v_s1        <= issue_on_q && !done;
			last_s1     <= issue_idx_q == SCAN_LAST;
			v_s2        <= v_s1 && !done;
			last_s2     <= last_s1;
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q     <= S_SCAN;
						issue_on_q  <= 1'b1;
						issue_idx_q <= FIRST_CAND;
					end
				end
				S_SCAN: begin
					if (done) begin
						state_q     <= out_free ? S_IDLE : S_OUT;
						issue_on_q  <= 1'b0;
					end else if (issue_on_q) begin
						issue_on_q  <= (issue_idx_q != SCAN_LAST);
						issue_idx_q <= issue_next;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`PNCS_ASSERT_IMP(a_out_wait, state_q == S_OUT, out_valid_q, "waiting with empty output")
	`PNCS_ASSERT_IMP(a_never_skip, out_valid, (color_index != NEVER_A) && (color_index != NEVER_B), "excluded entry chosen")
	`PNCS_ASSERT_IMP(a_pipe_scan, v_s1 || v_s2, state_q == S_SCAN, "pipe busy outside scan")
	`PNCS_ASSERT_IMP(a_result_src, $rose(out_valid_q), $past(state_q == S_SCAN), "result without scan")

endmodule
